// File: hdl/inverse_square_light_field_defines.svh
// assertion macros shared by the inverse-square light field rtl
// no dependencies; included by the modules that carry assertions
`ifndef INVERSE_SQUARE_LIGHT_FIELD_DEFINES_SVH
`define INVERSE_SQUARE_LIGHT_FIELD_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define ISLF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("islf check failed");

// antecedent implies consequent in the next cycle
`define ISLF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("islf check failed");

`endif

// File: hdl/islf_pkg.sv
// shared types and constants of the inverse-square light field block
// no dependencies
package islf_pkg;

	localparam int LIU_W       = 7;
	localparam int SCALE_W     = 32;
	localparam int SLOT_W      = 6;
	localparam int LUM_W       = 48;
	localparam int RECIP_QW    = 25;  // quotient bits of 2^24 / d
	localparam int QUEUE_DEPTH = 2;

	localparam logic [LIU_W-1:0]   LIU_RESET   = 7'd64;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd65536;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic CFG_LIGHTS_IN_USE = 1'b0;
	localparam logic CFG_LUM_SCALE     = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_MUL,
		ST_SAT
	} back_state_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_stat_t;

	typedef struct packed {
		logic idle;
	} back_stat_t;

endpackage

// File: hdl/islf_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies
module islf_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

// File: hdl/islf_fifo.sv
// short query queue between the front and back parts
// depends on islf_pkg and the assertion macro header
`include "inverse_square_light_field_defines.svh"
module islf_fifo import islf_pkg::*; #(
	parameter int WIDTH = 20
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output fifo_stat_t       stat
);
	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] slot_q [QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	assign rdata      = slot_q[rd_ptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CW'(QUEUE_DEPTH));

	`ISLF_ASSERT_SAME(a_no_push_full, clk, arst_n, push, !stat.full)
	`ISLF_ASSERT_SAME(a_no_pop_empty, clk, arst_n, pop, !stat.empty)
	`ISLF_ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(QUEUE_DEPTH))
endmodule

// File: hdl/islf_front.sv
// front part: takes request transactions, writes light positions, queues queries
// depends on islf_pkg
module islf_front import islf_pkg::*; #(
	parameter int MAX_LIGHTS = 64,
	parameter int COORD_BITS = 10
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	output logic                    req_ready,
	input  logic                    req_type,
	input  logic [SLOT_W-1:0]       light_slot,
	input  logic [COORD_BITS-1:0]   coord_x,
	input  logic [COORD_BITS-1:0]   coord_y,
	input  fifo_stat_t              fifo_stat,
	input  back_stat_t              back_stat,
	output logic                    fifo_push,
	output logic [2*COORD_BITS-1:0] fifo_wdata,
	output logic                    ram_wr_en,
	output logic [(MAX_LIGHTS > 1 ? $clog2(MAX_LIGHTS) : 1)-1:0] ram_wr_addr,
	output logic [2*COORD_BITS-1:0] ram_wr_data
);
	localparam int AW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;

	logic                  hold_q;
	logic                  type_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [COORD_BITS-1:0] x_q;
	logic [COORD_BITS-1:0] y_q;
	logic                  retire;
	logic                  accept;

	// a load waits until every earlier query has finished reading the store
	always_comb begin
		if (type_q == REQ_QUERY) begin
			retire = hold_q && !fifo_stat.full;
		end else begin
			retire = hold_q && fifo_stat.empty && back_stat.idle;
		end
	end

	assign req_ready = !hold_q || retire;
	assign accept    = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
		end else if (accept) begin
			hold_q <= 1'b1;
		end else if (retire) begin
			hold_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			type_q <= req_type;
			slot_q <= light_slot;
			x_q    <= coord_x;
			y_q    <= coord_y;
		end
	end

	assign fifo_push   = retire && (type_q == REQ_QUERY);
	assign fifo_wdata  = {x_q, y_q};
	assign ram_wr_en   = retire && (type_q == REQ_LOAD) && (32'(slot_q) < 32'(MAX_LIGHTS));
	assign ram_wr_addr = AW'(slot_q);
	assign ram_wr_data = {x_q, y_q};
endmodule

// File: hdl/islf_recip.sv
// pipelined reciprocal unit: floor(2^24 / d), one restoring step per stage
// depends on islf_pkg
module islf_recip import islf_pkg::*; #(
	parameter int DW = 21
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [DW-1:0]       divisor,
	output logic                out_valid,
	output logic [RECIP_QW-1:0] term,
	output logic                zero,
	output logic                busy
);
	logic [RECIP_QW-1:0] stg_v_q;
	logic [DW-1:0]       stg_r_q [RECIP_QW];
	logic [DW-1:0]       stg_d_q [RECIP_QW];
	logic [RECIP_QW-1:0] stg_q_q [RECIP_QW];
	logic                stg_z_q [RECIP_QW];

	for (genvar j = 0; j < RECIP_QW; j++) begin : g_stage
		logic                v_in;
		logic [DW-1:0]       r_in;
		logic [DW-1:0]       d_in;
		logic [RECIP_QW-1:0] q_in;
		logic                z_in;
		logic [DW:0]         rs;
		logic                ge;

		if (j == 0) begin : g_first
			assign v_in = in_valid;
			assign r_in = '0;
			assign d_in = divisor;
			assign q_in = '0;
			assign z_in = (divisor == '0);
		end else begin : g_next
			assign v_in = stg_v_q[j-1];
			assign r_in = stg_r_q[j-1];
			assign d_in = stg_d_q[j-1];
			assign q_in = stg_q_q[j-1];
			assign z_in = stg_z_q[j-1];
		end

		// only the top dividend bit is set, so it enters at the first step
		assign rs = {r_in, (j == 0) ? 1'b1 : 1'b0};
		assign ge = (rs >= {1'b0, d_in});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				stg_v_q[j] <= 1'b0;
			end else begin
				stg_v_q[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			stg_r_q[j] <= ge ? DW'(rs - {1'b0, d_in}) : DW'(rs);
			stg_d_q[j] <= d_in;
			stg_q_q[j] <= {q_in[RECIP_QW-2:0], ge};
			stg_z_q[j] <= z_in;
		end
	end

	assign out_valid = stg_v_q[RECIP_QW-1];
	assign zero      = stg_z_q[RECIP_QW-1];
	assign term      = stg_z_q[RECIP_QW-1] ? '0 : stg_q_q[RECIP_QW-1];
	assign busy      = |stg_v_q;
endmodule

// File: hdl/islf_back.sv
// back part: walks the light store for one query, sums reciprocals, scales, saturates
// depends on islf_pkg, islf_recip and the assertion macro header
`include "inverse_square_light_field_defines.svh"
module islf_back import islf_pkg::*; #(
	parameter int MAX_LIGHTS = 64,
	parameter int COORD_BITS = 10
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [LIU_W-1:0]        lights_in_use,
	input  logic [SCALE_W-1:0]      lum_scale,
	input  fifo_stat_t              fifo_stat,
	input  logic [2*COORD_BITS-1:0] fifo_rdata,
	output logic                    fifo_pop,
	output logic                    ram_rd_en,
	output logic [(MAX_LIGHTS > 1 ? $clog2(MAX_LIGHTS) : 1)-1:0] ram_rd_addr,
	input  logic [2*COORD_BITS-1:0] ram_rd_data,
	output back_stat_t              back_stat,
	output logic                    res_valid,
	input  logic                    res_ready,
	output logic [LUM_W-1:0]        luminosity,
	output logic                    at_light,
	output logic                    saturated
);
	localparam int AW    = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
	localparam int CNT_W = $clog2(MAX_LIGHTS + 1);
	localparam int SQW   = 2 * COORD_BITS;
	localparam int DW    = SQW + 1;
	localparam int SUM_W = RECIP_QW + AW;
	localparam int PW    = SUM_W + SCALE_W;
	localparam int LW    = PW - 16;
	localparam int EW    = (LW > LUM_W) ? LW : LUM_W + 1;

	back_state_t state_q, state_d;

	logic [CNT_W-1:0]      k_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      cnt_now;
	logic [COORD_BITS-1:0] px_q;
	logic [COORD_BITS-1:0] py_q;
	logic [SUM_W-1:0]      acc_q;
	logic                  hit_q;
	logic [PW-1:0]         prod_q;
	logic                  res_valid_q;
	logic [LUM_W-1:0]      lum_q;
	logic                  at_q;
	logic                  sat_q;

	logic                  issue;
	logic                  load_res;
	logic                  v_s1;
	logic                  v_s2;
	logic                  v_s3;
	logic [SQW-1:0]        sqx_s2;
	logic [SQW-1:0]        sqy_s2;
	logic [DW-1:0]         d_s3;
	logic [COORD_BITS-1:0] lx;
	logic [COORD_BITS-1:0] ly;
	logic [COORD_BITS-1:0] dx;
	logic [COORD_BITS-1:0] dy;
	logic                  rc_valid;
	logic [RECIP_QW-1:0]   rc_term;
	logic                  rc_zero;
	logic                  rc_busy;
	logic                  pipe_busy;
	logic [EW-1:0]         lum_ext;
	logic                  lum_over;

	assign cnt_now = (32'(lights_in_use) > 32'(MAX_LIGHTS)) ? CNT_W'(MAX_LIGHTS)
	                                                       : CNT_W'(lights_in_use);
	assign pipe_busy = v_s1 || v_s2 || v_s3 || rc_busy;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (!fifo_stat.empty) begin
					state_d = (cnt_now == '0) ? ST_MUL : ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				if (k_q == cnt_q - CNT_W'(1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!pipe_busy) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_SAT;
			end
			ST_SAT: begin
				if (!res_valid_q || res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		fifo_pop = 1'b0;
		issue    = 1'b0;
		load_res = 1'b0;
		unique case (state_q)
			ST_IDLE:  fifo_pop = !fifo_stat.empty;
			ST_ISSUE: issue = 1'b1;
			ST_SAT:   load_res = !res_valid_q || res_ready;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fifo_pop) begin
				k_q <= '0;
			end else if (issue) begin
				k_q <= k_q + CNT_W'(1);
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign ram_rd_en   = issue;
	assign ram_rd_addr = k_q[AW-1:0];

	assign lx = ram_rd_data[2*COORD_BITS-1:COORD_BITS];
	assign ly = ram_rd_data[COORD_BITS-1:0];
	assign dx = (lx >= px_q) ? lx - px_q : px_q - lx;
	assign dy = (ly >= py_q) ? ly - py_q : py_q - ly;

	always_ff @(posedge clk) begin
		if (fifo_pop) begin
			px_q  <= fifo_rdata[2*COORD_BITS-1:COORD_BITS];
			py_q  <= fifo_rdata[COORD_BITS-1:0];
			cnt_q <= cnt_now;
			acc_q <= '0;
			hit_q <= 1'b0;
		end else if (rc_valid) begin
			acc_q <= acc_q + SUM_W'(rc_term);
			hit_q <= hit_q | rc_zero;
		end
		sqx_s2 <= SQW'(dx) * SQW'(dx);
		sqy_s2 <= SQW'(dy) * SQW'(dy);
		d_s3   <= DW'(sqx_s2) + DW'(sqy_s2);
		if (state_q == ST_MUL) begin
			prod_q <= PW'(acc_q) * PW'(lum_scale);
		end
		if (load_res) begin
			lum_q <= lum_over ? {LUM_W{1'b1}} : lum_ext[LUM_W-1:0];
			at_q  <= hit_q;
			sat_q <= lum_over;
		end
	end

	islf_recip #(.DW(DW)) u_recip (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.divisor   (d_s3),
		.out_valid (rc_valid),
		.term      (rc_term),
		.zero      (rc_zero),
		.busy      (rc_busy)
	);

	assign lum_ext  = EW'(prod_q >> 16);
	assign lum_over = |lum_ext[EW-1:LUM_W];

	assign back_stat.idle = (state_q == ST_IDLE);
	assign res_valid      = res_valid_q;
	assign luminosity     = lum_q;
	assign at_light       = at_q;
	assign saturated      = sat_q;

	`ISLF_ASSERT_SAME(a_pop_in_idle, clk, arst_n, fifo_pop, state_q == ST_IDLE)
	`ISLF_ASSERT_SAME(a_issue_in_range, clk, arst_n, issue, k_q < cnt_q)
	`ISLF_ASSERT_SAME(a_terms_while_walking, clk, arst_n, rc_valid,
		state_q == ST_ISSUE || state_q == ST_DRAIN)
	`ISLF_ASSERT_NEXT(a_result_shown, clk, arst_n, load_res, res_valid)
endmodule

// File: hdl/inverse_square_light_field.sv
// top level of the inverse-square light field block: config registers and wiring
// depends on islf_pkg, islf_ram, islf_fifo, islf_front, islf_back
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  request  | req_valid / req_ready | req_type, light_slot, coord_x, coord_y
//  result   | res_valid / res_ready | luminosity, at_light, saturated
//  config   | cfg_we                | cfg_index, cfg_data
//
// a query walks N lights, N the clamped lights_in_use: one store
// read per cycle on the single ram read port, then a drain through
// the store read, distance and 25-stage reciprocal pipe, then scale and clip.
// a load retires once earlier queries are done; no clearing pass.
// reset clears the control state and loads the config defaults; the light
// store holds garbage until written. a stalled result blocks the next query's
// finish only; up to two queries wait in the queue behind it.
module inverse_square_light_field import islf_pkg::*; #(
	parameter int MAX_LIGHTS = 64,
	parameter int COORD_BITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// request transaction
	input  logic                  req_valid,
	output logic                  req_ready,
	input  logic                  req_type,
	input  logic [SLOT_W-1:0]     light_slot,
	input  logic [COORD_BITS-1:0] coord_x,
	input  logic [COORD_BITS-1:0] coord_y,
	// result transaction
	output logic                  res_valid,
	input  logic                  res_ready,
	output logic [LUM_W-1:0]      luminosity,
	output logic                  at_light,
	output logic                  saturated,
	// register writes
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [SCALE_W-1:0]    cfg_data
);
	localparam int AW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
	localparam int EW = 2 * COORD_BITS;

	logic [LIU_W-1:0]   liu_q;
	logic [SCALE_W-1:0] scale_q;

	// front to queue and store
	logic          fifo_push;
	logic [EW-1:0] fifo_wdata;
	logic          fifo_pop;
	logic [EW-1:0] fifo_rdata;
	fifo_stat_t    fifo_stat;
	back_stat_t    back_stat;
	logic          ram_wr_en;
	logic [AW-1:0] ram_wr_addr;
	logic [EW-1:0] ram_wr_data;
	logic          ram_rd_en;
	logic [AW-1:0] ram_rd_addr;
	logic [EW-1:0] ram_rd_data;

	// config writes must land only while idle (the user's duty, not enforced here); no shadowing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			liu_q   <= LIU_RESET;
			scale_q <= SCALE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LIGHTS_IN_USE: liu_q   <= cfg_data[LIU_W-1:0];
				CFG_LUM_SCALE:     scale_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// front: holds one request transaction and retires it
	islf_front #(
		.MAX_LIGHTS (MAX_LIGHTS),
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req_type    (req_type),
		.light_slot  (light_slot),
		.coord_x     (coord_x),
		.coord_y     (coord_y),
		.fifo_stat   (fifo_stat),
		.back_stat   (back_stat),
		.fifo_push   (fifo_push),
		.fifo_wdata  (fifo_wdata),
		.ram_wr_en   (ram_wr_en),
		.ram_wr_addr (ram_wr_addr),
		.ram_wr_data (ram_wr_data)
	);

	// query points waiting for the back part
	islf_fifo #(.WIDTH(EW)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fifo_push),
		.wdata  (fifo_wdata),
		.pop    (fifo_pop),
		.rdata  (fifo_rdata),
		.stat   (fifo_stat)
	);

	// light positions, x in the upper half of each word
	islf_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_LIGHTS)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// back: per-light walk, reciprocal sum, scale and clip, result register
	islf_back #(
		.MAX_LIGHTS (MAX_LIGHTS),
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.lights_in_use (liu_q),
		.lum_scale     (scale_q),
		.fifo_stat     (fifo_stat),
		.fifo_rdata    (fifo_rdata),
		.fifo_pop      (fifo_pop),
		.ram_rd_en     (ram_rd_en),
		.ram_rd_addr   (ram_rd_addr),
		.ram_rd_data   (ram_rd_data),
		.back_stat     (back_stat),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.luminosity    (luminosity),
		.at_light      (at_light),
		.saturated     (saturated)
	);
endmodule
